// ----- rtl/histeq_pkg.sv -----
// Shared constants, types and codes for the histogram equalizer.
package histeq_pkg;

   localparam int COUNT_WIDTH    = 20;
   localparam int TOTAL_WIDTH    = 21;
   localparam int PIXEL_WIDTH    = 8;
   localparam int NUM_BINS       = 256;
   localparam int BIN_ADDR_WIDTH = 8;
   localparam int OUT_MAX        = 255;

   // Each bin adds 2 * 255 times its count to the running numerator.
   localparam int BIN_SCALE      = 2 * OUT_MAX;
   localparam int PROD_WIDTH     = COUNT_WIDTH + 9;
   localparam int CUM_WIDTH      = COUNT_WIDTH + BIN_ADDR_WIDTH;
   localparam int NUM_WIDTH      = CUM_WIDTH + 10;
   localparam int ACC_WIDTH      = TOTAL_WIDTH + 9;
   localparam int CMP_WIDTH      = (NUM_WIDTH > ACC_WIDTH) ? NUM_WIDTH : ACC_WIDTH;

   localparam logic FUNC_COUNT = 1'b0;
   localparam logic FUNC_MAP   = 1'b1;

   typedef struct packed {
      logic                      busy;
      logic                      rd_en;
      logic [BIN_ADDR_WIDTH-1:0] rd_addr;
      logic                      wr_en;
      logic [BIN_ADDR_WIDTH-1:0] wr_addr;
      logic [PIXEL_WIDTH-1:0]    wr_data;
   } build_port_type;

endpackage

// ----- rtl/histogram_equalizer.sv -----
// Two-pass 8-bit histogram equalizer: count and map pipeline around two RAMs.
// Count and map items are taken one per cycle while req_stall is low; a map result is
// registered in the map RAM read and then in the output register, and the bin
// read-modify-write forwards back-to-back hits. A count item flagged last starts the
// table build, which stalls input until the builder is idle again after every bin.
// Reset is synchronous; bins and table read as zero through valid flags, no sweep.
module histogram_equalizer
   import histeq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_func,
   input  logic [PIXEL_WIDTH-1:0] req_pixel,
   input  logic                   req_last,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PIXEL_WIDTH-1:0] rsp_mapped_pixel,
   output logic                   rsp_last_out
);

   build_port_type            build;
   logic                      accept;
   logic                      s1_go;
   logic                      s1_count;
   logic                      s1_map;
   logic                      s1_valid_ff, s1_valid_in;
   logic                      s1_func_ff;
   logic [PIXEL_WIDTH-1:0]    s1_pixel_ff;
   logic                      s1_last_ff;
   logic [NUM_BINS-1:0]       bin_valid_ff, bin_valid_in;
   logic                      table_valid_ff, table_valid_in;
   logic [TOTAL_WIDTH-1:0]    total_ff, total_in;
   logic                      bin_rd_en;
   logic [BIN_ADDR_WIDTH-1:0] bin_rd_addr;
   logic [BIN_ADDR_WIDTH-1:0] bin_rd_addr_ff, bin_rd_addr_in;
   logic [COUNT_WIDTH-1:0]    bin_rd_data;
   logic [COUNT_WIDTH-1:0]    bin_value;
   logic [COUNT_WIDTH-1:0]    bin_base;
   logic [COUNT_WIDTH-1:0]    bin_next;
   logic                      fwd_valid_ff, fwd_valid_in;
   logic [BIN_ADDR_WIDTH-1:0] fwd_addr_ff;
   logic [COUNT_WIDTH-1:0]    fwd_data_ff;
   logic [PIXEL_WIDTH-1:0]    map_rd_data;
   logic                      map_rd_en;
   logic                      clear;
   logic                      out_valid_ff, out_valid_in;
   logic [PIXEL_WIDTH-1:0]    out_pixel_ff, out_pixel_in;
   logic                      out_last_ff, out_last_in;

   assign s1_count  = s1_valid_ff && (s1_func_ff == FUNC_COUNT);
   assign s1_map    = s1_valid_ff && (s1_func_ff == FUNC_MAP);
   assign s1_go     = !(s1_map && out_valid_ff && rsp_stall);
   assign req_stall = build.busy || !s1_go || (s1_count && s1_last_ff);
   assign accept    = req_valid && !req_stall;
   assign clear     = s1_map && s1_go && s1_last_ff;

   assign s1_valid_in = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   // Bin RAM: the builder owns the read port while it runs.
   assign bin_rd_en      = build.rd_en || (accept && (req_func == FUNC_COUNT));
   assign bin_rd_addr    = build.rd_en ? build.rd_addr : req_pixel;
   assign bin_rd_addr_in = bin_rd_en ? bin_rd_addr : bin_rd_addr_ff;
   assign bin_value      = bin_valid_ff[bin_rd_addr_ff] ? bin_rd_data : '0;

   // The write of the previous item lands at the edge that captures this read.
   assign bin_base = (fwd_valid_ff && (fwd_addr_ff == s1_pixel_ff)) ? fwd_data_ff : bin_value;
   assign bin_next = (bin_base == '1) ? bin_base : bin_base + 1'b1;
   assign fwd_valid_in = s1_count;

   histeq_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (NUM_BINS)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (s1_count),
      .wr_addr (s1_pixel_ff),
      .wr_data (bin_next),
      .rd_en   (bin_rd_en),
      .rd_addr (bin_rd_addr),
      .rd_data (bin_rd_data)
   );

   assign map_rd_en = accept && (req_func == FUNC_MAP);

   histeq_ram #(
      .WIDTH (PIXEL_WIDTH),
      .DEPTH (NUM_BINS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (build.wr_en),
      .wr_addr (build.wr_addr),
      .wr_data (build.wr_data),
      .rd_en   (map_rd_en),
      .rd_addr (req_pixel),
      .rd_data (map_rd_data)
   );

   // The total seen at start must already include the count item flagged last.
   histeq_build u_build (
      .clock     (clock),
      .reset     (reset),
      .start     (s1_count && s1_last_ff),
      .total     (total_in),
      .bin_value (bin_value),
      .port      (build)
   );

   always_comb begin
      bin_valid_in = bin_valid_ff;
      if (clear) begin
         bin_valid_in = '0;
      end else if (s1_count) begin
         bin_valid_in[s1_pixel_ff] = 1'b1;
      end
   end

   always_comb begin
      total_in = total_ff;
      if (clear) begin
         total_in = '0;
      end else if (s1_count && (total_ff != '1)) begin
         total_in = total_ff + 1'b1;
      end
   end

   assign table_valid_in = table_valid_ff || build.wr_en;

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_pixel_in = out_pixel_ff;
      out_last_in  = out_last_ff;
      if (s1_map && s1_go) begin
         out_valid_in = 1'b1;
         out_pixel_in = table_valid_ff ? map_rd_data : '0;
         out_last_in  = s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         bin_valid_ff   <= '0;
         table_valid_ff <= 1'b0;
         total_ff       <= '0;
         fwd_valid_ff   <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         bin_valid_ff   <= bin_valid_in;
         table_valid_ff <= table_valid_in;
         total_ff       <= total_in;
         fwd_valid_ff   <= fwd_valid_in;
         out_valid_ff   <= out_valid_in;
      end
      if (accept) begin
         s1_func_ff  <= req_func;
         s1_pixel_ff <= req_pixel;
         s1_last_ff  <= req_last;
      end
      bin_rd_addr_ff <= bin_rd_addr_in;
      fwd_addr_ff    <= s1_pixel_ff;
      fwd_data_ff    <= bin_next;
      out_pixel_ff   <= out_pixel_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_mapped_pixel = out_pixel_ff;
   assign rsp_last_out     = out_last_ff;

endmodule

// ----- rtl/histeq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module histeq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/histeq_build.sv -----
// Sequencer that walks the histogram and writes the equalization table.
module histeq_build
   import histeq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [TOTAL_WIDTH-1:0]     total,
   input  logic [COUNT_WIDTH-1:0]     bin_value,
   output build_port_type             port
);

   typedef enum logic [4:0] {
      B_IDLE = 5'b00001,
      B_READ = 5'b00010,
      B_MUL  = 5'b00100,
      B_ACC  = 5'b01000,
      B_STEP = 5'b10000
   } build_state_type;

   build_state_type           state_ff, state_in;
   logic [BIN_ADDR_WIDTH-1:0] idx_ff, idx_in;
   logic [PIXEL_WIDTH-1:0]    k_ff, k_in;
   logic [CMP_WIDTH-1:0]      num_ff, num_in;
   logic [CMP_WIDTH-1:0]      acc_ff, acc_in;
   logic [PROD_WIDTH-1:0]     prod_ff, prod_in;
   logic [CMP_WIDTH-1:0]      step;
   logic                      can_step;

   // acc holds 2 * total * (k + 1); k rises while that stays within the numerator.
   assign step     = CMP_WIDTH'({total, 1'b0});
   assign can_step = (total != '0) && (k_ff != PIXEL_WIDTH'(OUT_MAX)) && (acc_ff <= num_ff);
   assign prod_in  = PROD_WIDTH'(bin_value) * PROD_WIDTH'(BIN_SCALE);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      num_in       = num_ff;
      acc_in       = acc_ff;
      port.busy    = (state_ff != B_IDLE);
      port.rd_en   = 1'b0;
      port.rd_addr = idx_ff;
      port.wr_en   = 1'b0;
      port.wr_addr = idx_ff;
      port.wr_data = (total == '0) ? '0 : k_ff;
      case (state_ff)
         B_IDLE: begin
            if (start) begin
               state_in = B_READ;
               idx_in   = '0;
               k_in     = '0;
               num_in   = CMP_WIDTH'(total);
               acc_in   = step;
            end
         end
         B_READ: begin
            port.rd_en = 1'b1;
            state_in   = B_MUL;
         end
         B_MUL: begin
            state_in = B_ACC;
         end
         B_ACC: begin
            num_in   = num_ff + CMP_WIDTH'(prod_ff);
            state_in = B_STEP;
         end
         B_STEP: begin
            if (can_step) begin
               k_in   = k_ff + 1'b1;
               acc_in = acc_ff + step;
            end else begin
               port.wr_en = 1'b1;
               idx_in     = idx_ff + 1'b1;
               if (idx_ff == BIN_ADDR_WIDTH'(NUM_BINS - 1)) begin
                  state_in = B_IDLE;
               end else begin
                  state_in = B_READ;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff  <= idx_in;
      k_ff    <= k_in;
      num_ff  <= num_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

endmodule
